/* sv/dtd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package dtd_pkg;

  localparam int unsigned DISP_W     = 16;
  localparam int unsigned MAG_W      = DISP_W - 1;
  localparam int unsigned DEPTH_W    = 16;
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned QUO_W      = DEPTH_W;
  localparam int unsigned DEN_W      = MAG_W;
  localparam int unsigned REM_W      = DEN_W + QUO_W;
  localparam int unsigned GAIN_SHIFT = 8;
  localparam int unsigned BITS_PER_STAGE = 2;
  localparam int unsigned DIV_STAGES = QUO_W / BITS_PER_STAGE;

  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned REG_SEL_BIT = 2;
  localparam logic REG_FOCAL    = 1'b0;
  localparam logic REG_BASELINE = 1'b1;

  typedef struct packed {
    logic               inv;
    logic               ovf;
    logic [DEN_W-1:0]   den;
    logic [REM_W-1:0]   rem;
    logic [QUO_W-1:0]   quo;
  } div_beat_t;

endpackage
`default_nettype wire

/* sv/dtd_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module dtd_front #(
  parameter int unsigned DISP_FRAC_SCALE = 16
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire logic [dtd_pkg::CFG_W-1:0]       focal_i,
  input  wire logic [dtd_pkg::CFG_W-1:0]       baseline_i,
  input  wire logic                            valid_i,
  output logic                                 ready_o,
  input  wire logic signed [dtd_pkg::DISP_W-1:0] disparity_i,
  output logic                                 valid_o,
  input  wire logic                            ready_i,
  output dtd_pkg::div_beat_t                   beat_o
);

  localparam int unsigned SCALE_W = $clog2(DISP_FRAC_SCALE + 1);
  localparam int unsigned PROD_W  = 2 * dtd_pkg::CFG_W;
  localparam int unsigned NUM_W   = PROD_W + SCALE_W;
  localparam logic [NUM_W-1:0] SCALE_N = NUM_W'(DISP_FRAC_SCALE);
  localparam logic [dtd_pkg::DEN_W-1:0] SCALE_D = dtd_pkg::DEN_W'(DISP_FRAC_SCALE);

  logic                         v1_q, v2_q, v3_q;
  logic                         r1, r2, r3;
  logic                         inv1_q, metric1_q;
  logic [dtd_pkg::MAG_W-1:0]    mag1_q;
  logic [PROD_W-1:0]            fb1_q;
  logic                         inv2_q;
  logic [NUM_W-1:0]             num2_q;
  logic [dtd_pkg::DEN_W-1:0]    den2_q;
  dtd_pkg::div_beat_t           beat3_q, beat3_d;
  logic                         inv1_d, metric1_d;
  logic [NUM_W-1:0]             num2_d;
  logic [dtd_pkg::DEN_W-1:0]    den2_d;
  logic                         ovf3;

  assign r3      = !v3_q || ready_i;
  assign r2      = !v2_q || r3;
  assign r1      = !v1_q || r2;
  assign ready_o = r1;
  assign valid_o = v3_q;
  assign beat_o  = beat3_q;

  assign inv1_d    = disparity_i[dtd_pkg::DISP_W-1] || (disparity_i == '0);
  assign metric1_d = (focal_i >= dtd_pkg::CFG_W'(2)) && (baseline_i != '0);

  always_comb begin
    if (metric1_q) begin
      num2_d = NUM_W'(fb1_q) * SCALE_N;
      den2_d = mag1_q;
    end else begin
      num2_d = NUM_W'({mag1_q, dtd_pkg::GAIN_SHIFT'(0)});
      den2_d = SCALE_D;
    end
  end

  assign ovf3 = num2_q >= (NUM_W'(den2_q) << dtd_pkg::QUO_W);

  always_comb begin
    beat3_d.inv = inv2_q;
    beat3_d.ovf = ovf3;
    beat3_d.den = den2_q;
    beat3_d.quo = '0;
    if (inv2_q || ovf3) begin
      beat3_d.rem = '0;
    end else begin
      beat3_d.rem = num2_q[dtd_pkg::REM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (r1) v1_q <= valid_i;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r1 && valid_i) begin
      inv1_q    <= inv1_d;
      metric1_q <= metric1_d;
      mag1_q    <= disparity_i[dtd_pkg::MAG_W-1:0];
      fb1_q     <= PROD_W'(focal_i) * PROD_W'(baseline_i);
    end
    if (r2 && v1_q) begin
      inv2_q <= inv1_q;
      num2_q <= num2_d;
      den2_q <= den2_d;
    end
    if (r3 && v2_q) begin
      beat3_q <= beat3_d;
    end
  end

endmodule
`default_nettype wire

/* sv/dtd_div_stage.sv */
`timescale 1ns / 1ps
`default_nettype none
module dtd_div_stage #(
  parameter int unsigned BIT_HI = 15
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire logic                 valid_i,
  output logic                      ready_o,
  input  wire dtd_pkg::div_beat_t   beat_i,
  output logic                      valid_o,
  input  wire logic                 ready_i,
  output dtd_pkg::div_beat_t        beat_o
);

  localparam int unsigned BIT_LO = BIT_HI - 1;

  logic                          valid_q;
  dtd_pkg::div_beat_t            beat_q, beat_d;
  logic [dtd_pkg::REM_W-1:0]     trial_hi, trial_lo, rem_mid;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign beat_o  = beat_q;

  assign trial_hi = dtd_pkg::REM_W'(beat_i.den) << BIT_HI;
  assign trial_lo = dtd_pkg::REM_W'(beat_i.den) << BIT_LO;

  always_comb begin
    beat_d  = beat_i;
    rem_mid = beat_i.rem;
    if (beat_i.rem >= trial_hi) begin
      rem_mid            = beat_i.rem - trial_hi;
      beat_d.quo[BIT_HI] = 1'b1;
    end
    beat_d.rem = rem_mid;
    if (rem_mid >= trial_lo) begin
      beat_d.rem         = rem_mid - trial_lo;
      beat_d.quo[BIT_LO] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      beat_q <= beat_d;
    end
  end

endmodule
`default_nettype wire

/* sv/disparity_to_depth_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Signals                              Payload
// s_axis    in   s_axis_tvalid/tready/tdata[15:0]     disparity (signed, 4 frac bits)
// m_axis    out  m_axis_tvalid/tready/tdata[15:0]     depth (unsigned)
// apb       in   psel/penable/pwrite/paddr/pwdata     0x0 focal length, 0x4 baseline
//
// One beat per cycle sustained while m_axis accepts; 3 operand stages, 8 divider
// stages resolving 2 quotient bits each, 1 output register.
// Reset clears the stage valid bits and both registers to zero.
// Each stage has its own valid bit and holds while the next is full and stalled;
// empty stages refill, so a stall at m_axis loses and repeats nothing.
module disparity_to_depth_unit #(
  parameter int unsigned DISP_FRAC_SCALE = 16
) (
  input  wire                                     clk_i,
  input  wire                                     rst_ni,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [dtd_pkg::DISP_W-1:0]         s_axis_tdata,  // [15:0] disparity
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output logic [dtd_pkg::DEPTH_W-1:0]             m_axis_tdata,  // [15:0] depth
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [dtd_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [dtd_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [dtd_pkg::APB_DATA_W-1:0]          prdata,
  output logic                                    pready
);

  logic [dtd_pkg::CFG_W-1:0]    focal_q, baseline_q;
  logic                         cfg_wr;
  logic                         chain_valid [dtd_pkg::DIV_STAGES+1];
  logic                         chain_ready [dtd_pkg::DIV_STAGES+1];
  dtd_pkg::div_beat_t           chain_beat  [dtd_pkg::DIV_STAGES+1];
  logic                         out_valid_q;
  logic [dtd_pkg::DEPTH_W-1:0]  depth_q, depth_d;
  dtd_pkg::div_beat_t           last_beat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    if (paddr[dtd_pkg::REG_SEL_BIT] == dtd_pkg::REG_BASELINE) begin
      prdata = dtd_pkg::APB_DATA_W'(baseline_q);
    end else begin
      prdata = dtd_pkg::APB_DATA_W'(focal_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_q    <= '0;
      baseline_q <= '0;
    end else if (cfg_wr) begin
      if (paddr[dtd_pkg::REG_SEL_BIT] == dtd_pkg::REG_FOCAL) begin
        focal_q <= pwdata[dtd_pkg::CFG_W-1:0];
      end else begin
        baseline_q <= pwdata[dtd_pkg::CFG_W-1:0];
      end
    end
  end

  dtd_front #(
    .DISP_FRAC_SCALE(DISP_FRAC_SCALE)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .focal_i     (focal_q),
    .baseline_i  (baseline_q),
    .valid_i     (s_axis_tvalid),
    .ready_o     (s_axis_tready),
    .disparity_i (s_axis_tdata),
    .valid_o     (chain_valid[0]),
    .ready_i     (chain_ready[0]),
    .beat_o      (chain_beat[0])
  );

  for (genvar j = 0; j < dtd_pkg::DIV_STAGES; j++) begin : g_div
    dtd_div_stage #(
      .BIT_HI(dtd_pkg::QUO_W - 1 - dtd_pkg::BITS_PER_STAGE * j)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_valid[j]),
      .ready_o (chain_ready[j]),
      .beat_i  (chain_beat[j]),
      .valid_o (chain_valid[j+1]),
      .ready_i (chain_ready[j+1]),
      .beat_o  (chain_beat[j+1])
    );
  end

  assign last_beat = chain_beat[dtd_pkg::DIV_STAGES];
  assign chain_ready[dtd_pkg::DIV_STAGES] = !out_valid_q || m_axis_tready;

  always_comb begin
    if (last_beat.inv) begin
      depth_d = '0;
    end else if (last_beat.ovf) begin
      depth_d = '1;
    end else begin
      depth_d = last_beat.quo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (chain_ready[dtd_pkg::DIV_STAGES]) begin
      out_valid_q <= chain_valid[dtd_pkg::DIV_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (chain_ready[dtd_pkg::DIV_STAGES] && chain_valid[dtd_pkg::DIV_STAGES]) begin
      depth_q <= depth_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = depth_q;

`ifndef NO_ASSERTIONS
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a stalled output");

  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (chain_valid[0] && !chain_beat[0].inv) |-> (chain_beat[0].den != '0))
    else $error("zero divisor entered the divider");

  a_quo_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (chain_valid[dtd_pkg::DIV_STAGES] && last_beat.ovf && !last_beat.inv)
      |-> (last_beat.quo == '0))
    else $error("quotient bits set on a saturated beat");
`endif

endmodule
`default_nettype wire

/* verif/disparity_to_depth_unit_tb.sv */
`timescale 1ns / 1ps
module disparity_to_depth_unit_tb;

  localparam int unsigned DISP_W      = dtd_pkg::DISP_W;
  localparam int unsigned DEPTH_W     = dtd_pkg::DEPTH_W;
  localparam int unsigned CFG_W       = dtd_pkg::CFG_W;
  localparam int unsigned APB_ADDR_W  = dtd_pkg::APB_ADDR_W;
  localparam int unsigned APB_DATA_W  = dtd_pkg::APB_DATA_W;
  localparam int unsigned FRAC_SCALE  = 16;
  localparam int unsigned SCALED_GAIN = 256;
  localparam logic [DEPTH_W-1:0] DEPTH_SAT = '1;
  localparam logic [APB_ADDR_W-1:0] ADDR_FOCAL    = APB_ADDR_W'(4 * dtd_pkg::REG_FOCAL);
  localparam logic [APB_ADDR_W-1:0] ADDR_BASELINE = APB_ADDR_W'(4 * dtd_pkg::REG_BASELINE);
  localparam int RAND_BLOCKS     = 10;
  localparam int BLOCK_ITEMS     = 125;
  localparam int PRESSURE_ITEMS  = 60;
  localparam int HOLD_CYCLES     = 400;
  localparam int TAIL_CYCLES     = 30;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int REPORT_LIMIT    = 10;

  typedef struct packed {
    logic [CFG_W-1:0]   focal;
    logic [CFG_W-1:0]   base;
    logic [DISP_W-1:0]  disp;
    bit                 typed;
    logic [DEPTH_W-1:0] depth;
  } disp_row_t;

  localparam int DIR_ROWS = 23;
  disp_row_t dir_rows [DIR_ROWS] = '{
    '{16'd0,     16'd0,     16'h0000, 1'b1, 16'd0},
    '{16'd0,     16'd0,     16'h0001, 1'b1, 16'd16},
    '{16'd0,     16'd0,     16'h0fff, 1'b1, 16'hfff0},
    '{16'd0,     16'd0,     16'h1000, 1'b1, 16'hffff},
    '{16'd0,     16'd0,     16'h7fff, 1'b1, 16'hffff},
    '{16'd0,     16'd0,     16'h8000, 1'b1, 16'd0},
    '{16'd0,     16'd0,     16'hffff, 1'b1, 16'd0},
    '{16'd1,     16'd65535, 16'h0010, 1'b1, 16'd256},
    '{16'd65535, 16'd0,     16'h0010, 1'b1, 16'd256},
    '{16'd2,     16'd1,     16'h0001, 1'b1, 16'd32},
    '{16'd2,     16'd1,     16'h0020, 1'b1, 16'd1},
    '{16'd2,     16'd1,     16'h0021, 1'b1, 16'd0},
    '{16'd2,     16'd1,     16'h0000, 1'b1, 16'd0},
    '{16'd2,     16'd1,     16'h8000, 1'b1, 16'd0},
    '{16'd65535, 16'd65535, 16'h0001, 1'b1, 16'hffff},
    '{16'd65535, 16'd65535, 16'h7fff, 1'b1, 16'hffff},
    '{16'd65535, 16'd65535, 16'h5555, 1'b0, 16'd0},
    '{16'd100,   16'd50,    16'h0002, 1'b1, 16'd40000},
    '{16'd100,   16'd50,    16'h0001, 1'b1, 16'hffff},
    '{16'd100,   16'd50,    16'h7fff, 1'b1, 16'd2},
    '{16'd100,   16'd50,    16'haaaa, 1'b1, 16'd0},
    '{16'd100,   16'd50,    16'h0003, 1'b0, 16'd0},
    '{16'd100,   16'd50,    16'h0101, 1'b0, 16'd0}
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [DISP_W-1:0]     s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [DEPTH_W-1:0]    m_axis_tdata;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  logic [DEPTH_W-1:0] expected_depths [$];
  logic [CFG_W-1:0]   focal_mirror = '0;
  logic [CFG_W-1:0]   base_mirror = '0;
  int                 depth_errors = 0;
  int                 tx_idle_pct = 0;
  int                 rx_stall_pct = 0;
  bit                 hold_req = 1'b0;
  int                 hold_left = 0;
  int                 cycles = 0;

  disparity_to_depth_unit #(
    .DISP_FRAC_SCALE(FRAC_SCALE)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #10 clk_i = ~clk_i;

  function automatic logic [DEPTH_W-1:0] depth_of(logic [DISP_W-1:0] disp,
                                                  logic [CFG_W-1:0] focal,
                                                  logic [CFG_W-1:0] base);
    logic [63:0] quo;
    if (disp == '0 || disp[DISP_W-1]) return '0;
    if (focal >= 2 && base >= 1)
      quo = (64'(FRAC_SCALE) * 64'(focal) * 64'(base)) / 64'(disp);
    else
      quo = (64'(disp) * 64'(SCALED_GAIN)) / 64'(FRAC_SCALE);
    return (quo > 64'(DEPTH_SAT)) ? DEPTH_SAT : quo[DEPTH_W-1:0];
  endfunction

  function automatic logic [DISP_W-1:0] rand_disp();
    logic [DISP_W-1:0] specials [5] = '{16'h0000, 16'h0001, 16'h7fff, 16'h8000, 16'hffff};
    case ($urandom_range(9))
      0, 1, 2: return DISP_W'($urandom_range(65535));
      3, 4:    return DISP_W'($urandom_range(64, 1));
      5, 6:    return DISP_W'($urandom_range(4096, 1));
      7:       return DISP_W'($urandom_range(32767, 1));
      8:       return DISP_W'(32768 + $urandom_range(32767));
      default: return specials[$urandom_range(4)];
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] rand_cfg(int unsigned floor_val);
    case ($urandom_range(2))
      0:       return CFG_W'($urandom_range(floor_val));
      1:       return CFG_W'($urandom_range(2000, floor_val + 1));
      default: return CFG_W'($urandom_range(65535));
    endcase
  endfunction

  task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [CFG_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {(APB_DATA_W - CFG_W)'($urandom), val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_depth_cfg(input logic [CFG_W-1:0] focal, input logic [CFG_W-1:0] base);
    while (expected_depths.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    apb_write(ADDR_FOCAL, focal);
    apb_write(ADDR_BASELINE, base);
    focal_mirror = focal;
    base_mirror  = base;
  endtask

  task automatic send_disp(input logic [DISP_W-1:0] disp, input logic [DEPTH_W-1:0] depth);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < tx_idle_pct) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= disp;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_depths.insert(expected_depths.size(), depth);
  endtask

  task automatic send_rand_disp();
    logic [DISP_W-1:0] disp;
    disp = rand_disp();
    send_disp(disp, depth_of(disp, focal_mirror, base_mirror));
  endtask

  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    logic [DEPTH_W-1:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_depths.size() == 0) begin
        if (depth_errors < REPORT_LIMIT)
          $display("unexpected depth beat: %0d", m_axis_tdata);
        depth_errors++;
      end else begin
        want = expected_depths.pop_front();
        if (m_axis_tdata !== want) begin
          if (depth_errors < REPORT_LIMIT)
            $display("depth mismatch: expected %0d, got %0d", want, m_axis_tdata);
          depth_errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    logic [DEPTH_W-1:0] depth;
    disp_row_t          row;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++) begin
      row = dir_rows[i];
      if (row.focal != focal_mirror || row.base != base_mirror) begin
        s_axis_tvalid <= 1'b0;
        set_depth_cfg(row.focal, row.base);
      end
      depth = row.typed ? row.depth : depth_of(row.disp, focal_mirror, base_mirror);
      send_disp(row.disp, depth);
    end

    for (int blk = 0; blk < RAND_BLOCKS; blk++) begin
      s_axis_tvalid <= 1'b0;
      case (blk)
        0:       set_depth_cfg(16'd2, 16'd1);
        1:       set_depth_cfg(16'd65535, 16'd65535);
        2:       set_depth_cfg(16'd0, 16'd0);
        3:       set_depth_cfg(16'd1, CFG_W'($urandom_range(65535)));
        4:       set_depth_cfg(CFG_W'($urandom_range(65535, 2)), 16'd0);
        default: set_depth_cfg(rand_cfg(1), rand_cfg(0));
      endcase
      if (blk == 2) begin
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_req     = 1'b1;
        repeat (PRESSURE_ITEMS) send_rand_disp();
      end
      case (blk % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 75; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 75; end
        default: begin tx_idle_pct = 20; rx_stall_pct = 20; end
      endcase
      repeat (BLOCK_ITEMS) send_rand_disp();
    end
    s_axis_tvalid <= 1'b0;

    while (expected_depths.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (expected_depths.size() != 0) depth_errors++;
    if (depth_errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
